[rtl/core/pva_pkg.sv]
// Shared types and constants for the polyphonic voice allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package pva_pkg;

   localparam int NUM_VOICES_DEF = 5;

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   localparam logic [1:0] KIND_TRIGGER = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_CUTOFF  = 2'd2;

   localparam logic [2:0] STG_IDLE    = 3'd0;
   localparam logic [2:0] STG_ATTACK  = 3'd1;
   localparam logic [2:0] STG_DECAY   = 3'd2;
   localparam logic [2:0] STG_SUSTAIN = 3'd3;
   localparam logic [2:0] STG_RELEASE = 3'd4;

   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_DECAY   = 3'd1;
   localparam logic [2:0] REG_SUSTAIN = 3'd2;
   localparam logic [2:0] REG_RELEASE = 3'd3;
   localparam logic [2:0] REG_BASE    = 3'd4;
   localparam logic [2:0] REG_AMOUNT  = 3'd5;

   localparam logic [15:0] ATTACK_RST  = 16'd10;
   localparam logic [15:0] DECAY_RST   = 16'd200;
   localparam logic [16:0] SUSTAIN_RST = 17'd32768;
   localparam logic [15:0] RELEASE_RST = 16'd300;
   localparam logic [14:0] BASE_RST    = 15'd2000;
   localparam logic [16:0] AMOUNT_RST  = 17'd32768;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [12:0] SWING_HZ   = 13'd6000;
   localparam logic [15:0] CUTOFF_MIN = 16'd20;
   localparam logic [15:0] CUTOFF_MAX = 16'd20000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic scan_clear;
      logic scan_step;
      logic on_apply;
      logic off_apply;
      logic t_sum;
      logic t_prep;
      logic div_start;
      logic t_wb;
      logic mul1;
      logic mul2;
      logic t_emit;
      logic last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       dt_zero;
      logic       match;
      logic       need_div;
      logic       div_busy;
      logic       rsp_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/pva_if.sv]
// Handshake channels of the voice allocator: request, response and register write.
// Depends on nothing.
`default_nettype none
interface pva_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [6:0]  note;
   logic [15:0] elapsed_ms;
   modport source (output valid, opcode, note, elapsed_ms, input ready);
   modport sink (input valid, opcode, note, elapsed_ms, output ready);
endinterface

interface pva_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  voice;
   logic [6:0]  voice_note;
   logic [14:0] cutoff_hz;
   logic [16:0] env_level;
   logic        last;
   modport source (output valid, kind, voice, voice_note, cutoff_hz, env_level, last,
                   input ready);
   modport sink (input valid, kind, voice, voice_note, cutoff_hz, env_level, last,
                 output ready);
endinterface

interface pva_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/pva_div.sv]
// Restoring serial divider, one quotient bit per cycle, 33-bit dividend.
// Depends on nothing.
`default_nettype none
module pva_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] num,
   input  wire logic [15:0] den,
   output logic             busy,
   output logic [16:0]      quo
);
   logic [32:0] sh_ff, sh_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic [16:0] trial;
   logic        fits;

   assign trial = {rem_ff[15:0], sh_ff[32]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      sh_in  = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         sh_in  = num;
         rem_in = '0;
         cnt_in = 6'd33;
      end else if (cnt_ff != 6'd0) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         sh_in  = {sh_ff[31:0], fits};
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign busy = cnt_ff != 6'd0;
   assign quo  = sh_ff[16:0];
endmodule
`default_nettype wire

[rtl/core/pva_datapath.sv]
// Voice state, envelope arithmetic, register file and response register.
// Depends on pva_pkg, pva_if and pva_div.
`default_nettype none
module pva_datapath #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
   parameter int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pva_pkg::cmd_type    cmd,
   input  wire logic [IW-1:0]       idx,
   input  wire logic                req_take,
   output pva_pkg::status_type      status,
   pva_req_if.sink                  req_if,
   pva_rsp_if.source                rsp_if,
   pva_csr_if.sink                  csr_if
);
   import pva_pkg::*;

   logic [15:0] attack_ff, decay_ff, release_ff;
   logic [16:0] sustain_ff, amount_ff;
   logic [14:0] base_ff;

   logic        busy_ff  [NUM_VOICES];
   logic [6:0]  note_ff  [NUM_VOICES];
   logic [31:0] age_ff   [NUM_VOICES];
   logic [2:0]  stage_ff [NUM_VOICES];
   logic [31:0] stime_ff [NUM_VOICES];
   logic [16:0] level_ff [NUM_VOICES];
   logic [31:0] age_cnt_ff;

   logic [1:0]  op_ff;
   logic [6:0]  rnote_ff;
   logic [15:0] dt_ff;

   logic          match_ff, free_ff;
   logic [IW-1:0] match_idx_ff, free_idx_ff, best_idx_ff, chosen;
   logic [31:0]   best_age_ff;

   logic [31:0] t_ff;
   logic [32:0] t_sum;
   logic [16:0] sus;
   logic [16:0] nlvl_ff, nlvl_in;
   logic [2:0]  nstg_ff, nstg_in;
   logic [31:0] ntime_ff, ntime_in;
   logic        need_ff, need_in, sub_ff, sub_in;
   logic [32:0] num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] wb_lvl;
   logic [33:0] p1_ff;
   logic [46:0] p2_ff;
   logic [15:0] cut_sum;
   logic [14:0] cut;

   logic        div_busy;
   logic [16:0] quo;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [3:0]  voice_ff;
   logic [6:0]  vnote_ff;
   logic [14:0] cut_ff;
   logic [16:0] lvl_out_ff;
   logic        last_ff;
   logic        rsp_free;

   assign sus    = (sustain_ff > ONE_Q16) ? ONE_Q16 : sustain_ff;
   assign chosen = match_ff ? match_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
   assign t_sum  = {1'b0, stime_ff[idx]} + {17'd0, dt_ff};

   // Envelope step decision; the division by the stage length runs afterwards.
   always_comb begin
      nstg_in  = stage_ff[idx];
      ntime_in = t_ff;
      nlvl_in  = '0;
      need_in  = 1'b0;
      sub_in   = 1'b0;
      num_in   = '0;
      den_in   = '0;
      case (stage_ff[idx])
         STG_ATTACK: begin
            if (attack_ff == 16'd0 || t_ff >= {16'd0, attack_ff}) begin
               nlvl_in  = ONE_Q16;
               nstg_in  = STG_DECAY;
               ntime_in = '0;
            end else begin
               num_in  = {1'b0, t_ff[15:0], 16'd0};
               den_in  = attack_ff;
               need_in = 1'b1;
            end
         end
         STG_DECAY: begin
            if (decay_ff == 16'd0 || t_ff >= {16'd0, decay_ff}) begin
               nlvl_in = sus;
               nstg_in = STG_SUSTAIN;
            end else begin
               num_in  = 33'(t_ff[15:0] * (ONE_Q16 - sus));
               den_in  = decay_ff;
               need_in = 1'b1;
               sub_in  = 1'b1;
            end
         end
         STG_SUSTAIN: begin
            nlvl_in = sus;
         end
         STG_RELEASE: begin
            if (release_ff == 16'd0 || t_ff >= {16'd0, release_ff}) begin
               nlvl_in = '0;
               nstg_in = STG_IDLE;
            end else begin
               num_in  = 33'(sus * (release_ff - t_ff[15:0]));
               den_in  = release_ff;
               need_in = 1'b1;
            end
         end
         default: begin
            nlvl_in = '0;
         end
      endcase
   end

   assign wb_lvl  = need_ff ? (sub_ff ? ONE_Q16 - quo : quo) : nlvl_ff;
   assign cut_sum = {1'b0, base_ff} + {1'b0, p2_ff[46:32]};
   assign cut     = (cut_sum < CUTOFF_MIN) ? CUTOFF_MIN[14:0] :
                    (cut_sum > CUTOFF_MAX) ? CUTOFF_MAX[14:0] : cut_sum[14:0];

   pva_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff    <= ATTACK_RST;
         decay_ff     <= DECAY_RST;
         sustain_ff   <= SUSTAIN_RST;
         release_ff   <= RELEASE_RST;
         base_ff      <= BASE_RST;
         amount_ff    <= AMOUNT_RST;
         age_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            busy_ff[i]  <= 1'b0;
            note_ff[i]  <= '0;
            age_ff[i]   <= '0;
            stage_ff[i] <= STG_IDLE;
            stime_ff[i] <= '0;
            level_ff[i] <= '0;
         end
      end else begin
         if (csr_if.valid) begin
            case (csr_if.index)
               REG_ATTACK:  attack_ff  <= csr_if.data[15:0];
               REG_DECAY:   decay_ff   <= csr_if.data[15:0];
               REG_SUSTAIN: sustain_ff <= csr_if.data;
               REG_RELEASE: release_ff <= csr_if.data[15:0];
               REG_BASE:    base_ff    <= csr_if.data[14:0];
               REG_AMOUNT:  amount_ff  <= csr_if.data;
               default: ;
            endcase
         end
         if (cmd.on_apply || cmd.off_apply || cmd.t_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.on_apply) begin
            stage_ff[chosen] <= STG_ATTACK;
            stime_ff[chosen] <= '0;
            level_ff[chosen] <= '0;
            note_ff[chosen]  <= rnote_ff;
            busy_ff[chosen]  <= 1'b1;
            age_ff[chosen]   <= age_cnt_ff + 32'd1;
            age_cnt_ff       <= age_cnt_ff + 32'd1;
         end
         if (cmd.off_apply) begin
            stage_ff[match_idx_ff] <= STG_RELEASE;
            stime_ff[match_idx_ff] <= '0;
            busy_ff[match_idx_ff]  <= 1'b0;
         end
         if (cmd.t_wb) begin
            stage_ff[idx] <= nstg_ff;
            stime_ff[idx] <= ntime_ff;
            level_ff[idx] <= wb_lvl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_if.opcode;
         rnote_ff <= req_if.note;
         dt_ff    <= req_if.elapsed_ms;
      end
      if (cmd.scan_clear) begin
         match_ff    <= 1'b0;
         free_ff     <= 1'b0;
         best_idx_ff <= '0;
         best_age_ff <= age_ff[0];
      end
      if (cmd.scan_step) begin
         if (!match_ff && busy_ff[idx] && note_ff[idx] == rnote_ff) begin
            match_ff     <= 1'b1;
            match_idx_ff <= idx;
         end
         if (!free_ff && !busy_ff[idx]) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx;
         end
         if (age_ff[idx] < best_age_ff) begin
            best_age_ff <= age_ff[idx];
            best_idx_ff <= idx;
         end
      end
      if (cmd.t_sum) begin
         t_ff <= t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
      end
      if (cmd.t_prep) begin
         nlvl_ff  <= nlvl_in;
         nstg_ff  <= nstg_in;
         ntime_ff <= ntime_in;
         need_ff  <= need_in;
         sub_ff   <= sub_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
      end
      if (cmd.mul1) begin
         p1_ff <= amount_ff * level_ff[idx];
      end
      if (cmd.mul2) begin
         p2_ff <= 47'(p1_ff * SWING_HZ);
      end
      if (cmd.on_apply) begin
         kind_ff    <= KIND_TRIGGER;
         voice_ff   <= 4'(chosen);
         vnote_ff   <= rnote_ff;
         cut_ff     <= '0;
         lvl_out_ff <= '0;
         last_ff    <= 1'b1;
      end
      if (cmd.off_apply) begin
         kind_ff    <= KIND_RELEASE;
         voice_ff   <= 4'(match_idx_ff);
         vnote_ff   <= rnote_ff;
         cut_ff     <= '0;
         lvl_out_ff <= level_ff[match_idx_ff];
         last_ff    <= 1'b1;
      end
      if (cmd.t_emit) begin
         kind_ff    <= KIND_CUTOFF;
         voice_ff   <= 4'(idx);
         vnote_ff   <= note_ff[idx];
         cut_ff     <= cut;
         lvl_out_ff <= level_ff[idx];
         last_ff    <= cmd.last;
      end
   end

   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.voice      = voice_ff;
   assign rsp_if.voice_note = vnote_ff;
   assign rsp_if.cutoff_hz  = cut_ff;
   assign rsp_if.env_level  = lvl_out_ff;
   assign rsp_if.last       = last_ff;

   assign status.op       = op_ff;
   assign status.dt_zero  = dt_ff == 16'd0;
   assign status.match    = match_ff;
   assign status.need_div = need_ff;
   assign status.div_busy = div_busy;
   assign status.rsp_free = rsp_free;
endmodule
`default_nettype wire

[rtl/core/pva_ctrl.sv]
// Sequencer of the voice allocator: voice scan, envelope steps, result beats.
// Depends on pva_pkg.
`default_nettype none
module pva_ctrl #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
   parameter int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     req_take,
   input  wire pva_pkg::status_type status,
   output pva_pkg::cmd_type         cmd,
   output logic [IW-1:0]            idx
);
   import pva_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_ON      = 4'd3;
   localparam logic [3:0] S_OFF     = 4'd4;
   localparam logic [3:0] S_TSUM    = 4'd5;
   localparam logic [3:0] S_TPREP   = 4'd6;
   localparam logic [3:0] S_TDSTART = 4'd7;
   localparam logic [3:0] S_TDWAIT  = 4'd8;
   localparam logic [3:0] S_TWB     = 4'd9;
   localparam logic [3:0] S_MUL1    = 4'd10;
   localparam logic [3:0] S_MUL2    = 4'd11;
   localparam logic [3:0] S_TEMIT   = 4'd12;

   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          at_last;

   assign at_last   = idx_ff == LAST_IDX;
   assign req_ready = state_ff == S_IDLE;
   assign req_take  = req_valid && req_ready;
   assign idx       = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.last = at_last;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in = '0;
            if (status.op == OP_NOTE_ON || status.op == OP_NOTE_OFF) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else if (status.op == OP_TICK && !status.dt_zero) begin
               state_in = S_TSUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (at_last) begin
               state_in = (status.op == OP_NOTE_ON) ? S_ON : S_OFF;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_ON: begin
            if (status.rsp_free) begin
               cmd.on_apply = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_OFF: begin
            if (!status.match) begin
               state_in = S_IDLE;
            end else if (status.rsp_free) begin
               cmd.off_apply = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_TSUM: begin
            cmd.t_sum = 1'b1;
            state_in  = S_TPREP;
         end
         S_TPREP: begin
            cmd.t_prep = 1'b1;
            state_in   = S_TDSTART;
         end
         S_TDSTART: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_TDWAIT;
            end else begin
               state_in = S_TWB;
            end
         end
         S_TDWAIT: begin
            if (!status.div_busy) begin
               state_in = S_TWB;
            end
         end
         S_TWB: begin
            cmd.t_wb = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_TEMIT;
         end
         S_TEMIT: begin
            if (status.rsp_free) begin
               cmd.t_emit = 1'b1;
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_TSUM;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/poly_voice_allocator_with_envelopes_core.sv]
// Top level of the polyphonic voice allocator with per-voice envelopes.
// Depends on pva_pkg, pva_if, pva_ctrl and pva_datapath.
`default_nettype none
// The block takes one request beat at a time. A note-on or note-off scans the
// voices one per cycle and presents its single beat once the scan is done and
// the response register is free. A tick with nonzero elapsed time walks the
// voices in turn, waiting on the 33-step serial divider for a voice whose
// envelope needs a division and on any response stall, and returns one cutoff
// beat per voice, the last one flagged. Zero-elapsed ticks, unknown opcodes
// and unmatched note-offs produce no beat. Registers may be written whenever
// no request is in flight; the write port is always ready.
module poly_voice_allocator_with_envelopes_core #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   pva_req_if.sink   req_if,
   pva_rsp_if.source rsp_if,
   pva_csr_if.sink   csr_if
);
   import pva_pkg::*;

   localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] idx;
   logic          req_take;

   pva_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .IW         (IW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_take  (req_take),
      .status    (status),
      .cmd       (cmd),
      .idx       (idx)
   );

   pva_datapath #(
      .NUM_VOICES (NUM_VOICES),
      .IW         (IW)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .idx      (idx),
      .req_take (req_take),
      .status   (status),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_if   (csr_if)
   );
endmodule
`default_nettype wire
